/* src/pbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types, codes and helper functions of the panel burn-in sequencer.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int PBS_MAX_FLOWS  = 8;
    localparam int PBS_MAX_CHECKS = 8;
    localparam int PBS_CFG_IDX_W  = 3;
    localparam int PBS_CFG_DATA_W = 64;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_POWER = 3'd1,
        CMD_UP    = 3'd2,
        CMD_DOWN  = 3'd3,
        CMD_MODE  = 3'd4
    } pbs_cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_PWR_ON  = 3'd1,
        ACT_PWR_OFF = 3'd2,
        ACT_PATTERN = 3'd3,
        ACT_CHECK   = 3'd4,
        ACT_STEP    = 3'd5,
        ACT_END     = 3'd6
    } pbs_act_t;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_CHECK = 2'd1,
        MODE_BURN  = 2'd2,
        MODE_DONE  = 2'd3
    } pbs_mode_t;

    typedef enum logic [2:0] {
        LED_OFF   = 3'd0,
        LED_RED   = 3'd1,
        LED_GREEN = 3'd2,
        LED_SLOW  = 3'd3,
        LED_FAST  = 3'd4
    } pbs_led_t;

    typedef enum logic [PBS_CFG_IDX_W-1:0] {
        CFG_CHECK_COUNT      = 3'd0,
        CFG_CHECK_PATTERNS   = 3'd1,
        CFG_FLOW_COUNT       = 3'd2,
        CFG_FLOW_STEP_COUNTS = 3'd3,
        CFG_FLOW_LOOP_LIMITS = 3'd4
    } pbs_cfg_idx_t;

    typedef struct packed {
        logic [2:0] command;
        logic       panel_found;
    } pbs_in_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] pattern_code;
        logic [2:0] flow_number;
        logic [7:0] step_number;
        logic       entry_step;
        logic [1:0] mode_now;
        logic [2:0] led_drive;
        logic       last_result;
    } pbs_out_t;

    // One or two results produced by a single input transaction.
    typedef struct packed {
        logic     two;
        pbs_out_t first;
        pbs_out_t second;
    } pbs_pair_t;

    typedef struct packed {
        logic [3:0]  check_count;
        logic [63:0] check_patterns;
        logic [3:0]  flow_count;
        logic [63:0] flow_step_counts;
        logic [63:0] flow_loop_limits;
    } pbs_cfg_t;

    typedef struct packed {
        pbs_mode_t  mode;
        logic       panel_valid;
        logic       panel_seen;
        logic [2:0] pattern_index;
        logic [2:0] flow_index;
        logic [7:0] step_index;
        logic       at_entry;
        logic [8:0] step_counter;
        pbs_led_t   led;
    } pbs_state_t;

    function automatic logic [7:0] byte_of(input logic [63:0] packed_word,
                                           input logic [2:0] k);
        return packed_word[k*8 +: 8];
    endfunction

    function automatic logic [3:0] flows_eff(input logic [3:0] c);
        return (c > 4'(PBS_MAX_FLOWS)) ? 4'(PBS_MAX_FLOWS) : c;
    endfunction

    function automatic logic [3:0] checks_eff(input logic [3:0] c);
        logic [3:0] v;
        v = (c > 4'(PBS_MAX_CHECKS)) ? 4'(PBS_MAX_CHECKS) : c;
        return (v == 4'd0) ? 4'd1 : v;
    endfunction

    function automatic pbs_out_t mk_res(input pbs_act_t act, input logic [7:0] pat,
                                        input logic [2:0] flow, input logic [7:0] step,
                                        input logic entry);
        pbs_out_t r;
        r              = '0;
        r.action       = act;
        r.pattern_code = pat;
        r.flow_number  = flow;
        r.step_number  = step;
        r.entry_step   = entry;
        return r;
    endfunction

endpackage

/* src/pbs_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_cfg
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module pbs_cfg
    import pbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [PBS_CFG_IDX_W-1:0]  cfg_index,
    input  logic [PBS_CFG_DATA_W-1:0] cfg_data,
    output pbs_cfg_t                  cfg
);

    pbs_cfg_t cfg_reg;
    pbs_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CHECK_COUNT:      cfg_next.check_count      = cfg_data[3:0];
                CFG_CHECK_PATTERNS:   cfg_next.check_patterns   = cfg_data;
                CFG_FLOW_COUNT:       cfg_next.flow_count       = cfg_data[3:0];
                CFG_FLOW_STEP_COUNTS: cfg_next.flow_step_counts = cfg_data;
                CFG_FLOW_LOOP_LIMITS: cfg_next.flow_loop_limits = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{check_count: 4'd1, check_patterns: 64'd0, flow_count: 4'd1,
                         flow_step_counts: 64'd0, flow_loop_limits: 64'd0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/pbs_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_core
// Input register, sequencer state and the single-pass step logic that turns
// one key or tick transaction into one or two results.
// ----------------------------------------------------------------------------
module pbs_core
    import pbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  pbs_in_t   in_data,
    input  pbs_cfg_t  cfg,
    input  logic      can_load,
    output logic      load,
    output pbs_pair_t pair
);

    logic       in_vld_reg;
    logic       in_vld_next;
    pbs_in_t    in_item_reg;
    pbs_state_t state_reg;
    pbs_state_t state_next;

    assign load     = in_vld_reg && can_load;
    assign in_stall = in_vld_reg && !load;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (load)
            in_vld_next = 1'b0;
        if (in_valid && !in_stall)
            in_vld_next = 1'b1;
    end

    always_comb
    begin
        pbs_state_t s;
        pbs_out_t   r0;
        pbs_out_t   r1;
        logic [1:0] n;
        logic [7:0] steps_b;
        logic [7:0] limit_b;
        logic [3:0] fnext;
        logic [7:0] snext;
        logic [2:0] top;

        s       = state_reg;
        r0      = mk_res(ACT_NONE, 8'd0, 3'd0, 8'd0, 1'b0);
        r1      = r0;
        n       = 2'd0;
        steps_b = byte_of(cfg.flow_step_counts, state_reg.flow_index);
        limit_b = byte_of(cfg.flow_loop_limits, state_reg.flow_index);
        fnext   = {1'b0, state_reg.flow_index} + 4'd1;
        snext   = 8'd0;
        top     = 3'(checks_eff(cfg.check_count) - 4'd1);

        unique case (in_item_reg.command)
            CMD_TICK:
            begin
                if (state_reg.mode == MODE_BURN)
                begin
                    if (s.at_entry)
                    begin
                        r0 = mk_res(ACT_STEP, 8'd0, s.flow_index, 8'd0, 1'b1);
                        n  = 2'd1;
                        s.step_index   = steps_b;
                        s.step_counter = 9'd0;
                        s.at_entry     = 1'b0;
                    end
                    s.step_counter = s.step_counter + 9'd1;
                    if (s.step_counter > {1'b0, limit_b})
                    begin
                        s.at_entry = 1'b1;
                        if (fnext >= flows_eff(cfg.flow_count))
                        begin
                            if (n == 2'd0)
                                r0 = mk_res(ACT_END, 8'd0, 3'd0, 8'd0, 1'b0);
                            else
                                r1 = mk_res(ACT_END, 8'd0, 3'd0, 8'd0, 1'b0);
                            n          = n + 2'd1;
                            s.led      = LED_FAST;
                            s.mode     = MODE_DONE;
                            s.flow_index = 3'd0;
                        end
                        else
                        begin
                            s.flow_index = fnext[2:0];
                        end
                    end
                    else
                    begin
                        snext = s.step_index + 8'd1;
                        if (snext >= steps_b)
                            snext = 8'd0;
                        s.step_index = snext;
                        if (n == 2'd0)
                            r0 = mk_res(ACT_STEP, 8'd0, s.flow_index, snext, 1'b0);
                        else
                            r1 = mk_res(ACT_STEP, 8'd0, s.flow_index, snext, 1'b0);
                        n = n + 2'd1;
                    end
                end
            end
            CMD_POWER:
            begin
                if (state_reg.mode == MODE_OFF)
                begin
                    if (in_item_reg.panel_found)
                    begin
                        s.panel_valid   = 1'b1;
                        s.panel_seen    = 1'b1;
                        s.led           = LED_GREEN;
                        s.pattern_index = 3'd0;
                        r0 = mk_res(ACT_PWR_ON, 8'd0, 3'd0, 8'd0, 1'b0);
                        n  = 2'd1;
                    end
                    else
                    begin
                        s.panel_valid = 1'b0;
                        s.led         = LED_RED;
                    end
                    s.mode = MODE_CHECK;
                end
                else
                begin
                    if (state_reg.panel_seen)
                    begin
                        r0 = mk_res(ACT_PWR_OFF, 8'd0, 3'd0, 8'd0, 1'b0);
                        n  = 2'd1;
                    end
                    s.led  = LED_OFF;
                    s.mode = MODE_OFF;
                end
            end
            CMD_UP, CMD_DOWN:
            begin
                if (state_reg.panel_valid)
                begin
                    if (state_reg.mode == MODE_CHECK)
                    begin
                        if (in_item_reg.command == CMD_UP)
                            s.pattern_index = (state_reg.pattern_index >= top) ? 3'd0
                                            : state_reg.pattern_index + 3'd1;
                        else
                            s.pattern_index = (state_reg.pattern_index == 3'd0) ? top
                                            : state_reg.pattern_index - 3'd1;
                        r0 = mk_res(ACT_PATTERN,
                                    byte_of(cfg.check_patterns, s.pattern_index),
                                    3'd0, 8'd0, 1'b0);
                        n  = 2'd1;
                    end
                    else if (state_reg.mode == MODE_BURN || state_reg.mode == MODE_DONE)
                    begin
                        s.pattern_index = 3'd0;
                        r0 = mk_res(ACT_PATTERN, byte_of(cfg.check_patterns, 3'd0),
                                    3'd0, 8'd0, 1'b0);
                        r1 = mk_res(ACT_CHECK, 8'd0, 3'd0, 8'd0, 1'b0);
                        n  = 2'd2;
                        s.led  = LED_GREEN;
                        s.mode = MODE_CHECK;
                    end
                end
            end
            CMD_MODE:
            begin
                if (state_reg.panel_valid)
                begin
                    if (state_reg.mode == MODE_CHECK)
                    begin
                        s.flow_index   = 3'd0;
                        s.at_entry     = 1'b1;
                        s.step_counter = 9'd0;
                        s.mode         = MODE_BURN;
                    end
                    else if (state_reg.mode == MODE_BURN)
                    begin
                        s.flow_index = (fnext >= flows_eff(cfg.flow_count)) ? 3'd0
                                     : fnext[2:0];
                        s.at_entry   = 1'b1;
                    end
                    else if (state_reg.mode == MODE_DONE)
                    begin
                        s.flow_index = 3'd0;
                        s.mode       = MODE_BURN;
                    end
                    if (s.mode == MODE_BURN)
                        s.led = LED_SLOW;
                end
            end
            default:
            begin
                s = state_reg;
            end
        endcase

        // Every result reports the mode and LED that hold after the input.
        r0.mode_now    = s.mode;
        r0.led_drive   = s.led;
        r0.last_result = (n != 2'd2);
        r1.mode_now    = s.mode;
        r1.led_drive   = s.led;
        r1.last_result = 1'b1;

        pair.two    = (n == 2'd2);
        pair.first  = r0;
        pair.second = r1;
        state_next  = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            state_reg  <= '{mode: MODE_OFF, panel_valid: 1'b0, panel_seen: 1'b0,
                           pattern_index: 3'd0, flow_index: 3'd0, step_index: 8'd0,
                           at_entry: 1'b1, step_counter: 9'd0, led: LED_OFF};
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (load)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_data;
    end

endmodule

/* src/pbs_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_out_buf
// Result register holding the one or two results of an input transaction
// and presenting them in order on the output channel.
// ----------------------------------------------------------------------------
module pbs_out_buf
    import pbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  pbs_pair_t pair,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_stall,
    output pbs_out_t  out_data
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       sel_reg;
    logic       sel_next;
    pbs_out_t   slot0_reg;
    pbs_out_t   slot1_reg;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = sel_reg ? slot1_reg : slot0_reg;
    assign pop       = out_valid && !out_stall;
    assign can_load  = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);

    always_comb
    begin
        count_next = count_reg;
        sel_next   = sel_reg;
        if (load)
        begin
            count_next = pair.two ? 2'd2 : 2'd1;
            sel_next   = 1'b0;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            sel_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= pair.first;
            slot1_reg <= pair.second;
        end
    end

endmodule

/* src/panel_burn_in_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_burn_in_sequencer
// Mode, pattern and burn-in flow controller for a display panel tester.
// ----------------------------------------------------------------------------
// Each input transaction is a key event (power, up, down, mode) or a tick,
// and it yields one or two result transactions in order; the last one of an
// input carries last_result. Every result reports the mode and LED drive
// that hold after the whole input. An input is held in an input register,
// worked in one pass of combinational logic and written to a two-entry
// result register, which hands out one result per cycle while out_stall is
// low. A new input is taken while the results of the previous one still
// wait on the output.
// Configuration registers are written through their own valid/ready channel,
// which is always ready; they should be written only while the block is idle.
// ----------------------------------------------------------------------------
module panel_burn_in_sequencer
    import pbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  pbs_in_t                   in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output pbs_out_t                  out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [PBS_CFG_IDX_W-1:0]  cfg_index,
    input  logic [PBS_CFG_DATA_W-1:0] cfg_data
);

    pbs_cfg_t  cfg;
    pbs_pair_t pair;
    logic      load;
    logic      can_load;

    // Configuration registers.
    pbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register, sequencer state and step logic.
    pbs_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg),
        .can_load (can_load),
        .load     (load),
        .pair     (pair)
    );

    // Result register that drains one result per cycle while out_stall is low.
    pbs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .pair      (pair),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
